// ===== rtl/bmp24_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants of the 24-bit bitmap stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_PIXEL      = 3'd0,
        ST_BAD_SIG    = 3'd1,
        ST_BAD_HDR    = 3'd2,
        ST_BAD_BPP    = 3'd3,
        ST_COMPRESSED = 3'd4,
        ST_BAD_SIZE   = 3'd5
    } status_t;

    // Parser phase of the front end
    typedef enum logic [2:0] {
        PH_SIG,
        PH_HDR,
        PH_SKIP,
        PH_PIX,
        PH_HALT
    } phase_t;

    // Info header flavor
    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_WIN,
        HDR_OS2
    } hdr_kind_t;

    // Transaction kinds between front and back
    typedef enum logic [1:0] {
        TK_START,
        TK_DATA,
        TK_ERROR
    } tok_kind_t;

    // Color component slot within a BGR triple
    typedef enum logic [1:0] {
        CMP_BLUE,
        CMP_GREEN,
        CMP_RED
    } comp_t;

    typedef struct packed {
        tok_kind_t kind;
        logic [7:0] data;
        status_t    code;
    } tok_t;

    localparam logic [7:0]  SIG_B          = 8'h42;
    localparam logic [7:0]  SIG_M          = 8'h4D;
    localparam logic [31:0] HDR_LEN_WIN    = 32'd40;
    localparam logic [31:0] HDR_LEN_OS2    = 32'd12;
    localparam logic [15:0] BPP_24         = 16'd24;

    // Byte positions of the last byte of each header field
    localparam logic [31:0] POS_OFFSET     = 32'd13;
    localparam logic [31:0] POS_HDR_SIZE   = 32'd17;
    localparam logic [31:0] POS_WIN_WIDTH  = 32'd21;
    localparam logic [31:0] POS_WIN_HEIGHT = 32'd25;
    localparam logic [31:0] POS_WIN_BPP    = 32'd29;
    localparam logic [31:0] POS_WIN_COMP   = 32'd33;
    localparam logic [31:0] POS_OS2_WIDTH  = 32'd19;
    localparam logic [31:0] POS_OS2_HEIGHT = 32'd21;
    localparam logic [31:0] POS_OS2_BPP    = 32'd25;

    // First byte after the last parsed field of each header
    localparam logic [31:0] WIN_DATA_START = 32'd34;
    localparam logic [31:0] OS2_DATA_START = 32'd26;

endpackage

// ===== rtl/bmp24_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24 stream interfaces
// Valid/ready channels for file bytes in and decoded pixels out.
// ----------------------------------------------------------------------------
interface bmp24_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface bmp24_pixel_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        last_pixel;

    modport source (output valid, output status, output red, output green, output blue,
                    output pixel_x, output pixel_y, output last_pixel, input ready);
    modport sink   (input valid, input status, input red, input green, input blue,
                    input pixel_x, input pixel_y, input last_pixel, output ready);
endinterface

// ===== rtl/bmp24_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_front
// Header parser: checks signature and header fields, skips to pixel data
// and forwards start, data and error transactions to the queue.
// ----------------------------------------------------------------------------
module bmp24_front
    import bmp24_pkg::*;
#(
    parameter int DIM_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    bmp24_byte_if.sink          file_bytes,
    input  logic                q_full,
    output logic                tok_valid,
    output tok_t                tok,
    output logic [DIM_BITS-1:0] tok_width,
    output logic [DIM_BITS-1:0] tok_height
);

    phase_t              phase_reg, phase_next;
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         offset_reg, offset_next;
    hdr_kind_t           hdr_reg, hdr_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;

    logic        accept;
    phase_t      cur_phase;
    logic [31:0] cur_pos;
    logic [31:0] cur_acc;
    hdr_kind_t   cur_hdr;
    logic [31:0] acc_new;
    logic [15:0] os2_val;
    logic        win_bad;
    logic        os2_bad;
    status_t     fail_code;
    logic        fail;
    logic        hdr_done;
    logic [31:0] data_start;
    logic        skip_done;

    assign file_bytes.ready = !q_full;
    assign accept = file_bytes.valid && !q_full;

    // A start byte restarts parsing with this byte as byte zero
    always_comb
    begin
        cur_phase = file_bytes.start_of_file ? PH_SIG   : phase_reg;
        cur_pos   = file_bytes.start_of_file ? 32'd0    : pos_reg;
        cur_acc   = file_bytes.start_of_file ? 32'd0    : acc_reg;
        cur_hdr   = file_bytes.start_of_file ? HDR_NONE : hdr_reg;
        acc_new   = {file_bytes.data_byte, cur_acc[31:8]};
        os2_val   = acc_new[31:16];
        win_bad   = (acc_new == 32'd0) || ((acc_new >> DIM_BITS) != 32'd0);
        os2_bad   = (os2_val == 16'd0) || os2_val[15]
                    || ((32'(os2_val) >> DIM_BITS) != 32'd0);
        skip_done = (cur_pos + 32'd1) == offset_reg;
    end

    // Field checks
    always_comb
    begin
        fail_code  = ST_PIXEL;
        hdr_done   = 1'b0;
        data_start = WIN_DATA_START;
        if (cur_phase == PH_SIG)
        begin
            if (cur_pos == 32'd0)
            begin
                if (file_bytes.data_byte != SIG_B)
                    fail_code = ST_BAD_SIG;
            end
            else if (file_bytes.data_byte != SIG_M)
                fail_code = ST_BAD_SIG;
        end
        else if (cur_phase == PH_HDR)
        begin
            if (cur_pos == POS_OFFSET)
            begin
                fail_code = ST_PIXEL;
            end
            else if (cur_pos == POS_HDR_SIZE)
            begin
                if (acc_new != HDR_LEN_WIN && acc_new != HDR_LEN_OS2)
                    fail_code = ST_BAD_HDR;
            end
            else if (cur_hdr == HDR_WIN)
            begin
                if (cur_pos == POS_WIN_WIDTH || cur_pos == POS_WIN_HEIGHT)
                begin
                    if (win_bad)
                        fail_code = ST_BAD_SIZE;
                end
                else if (cur_pos == POS_WIN_BPP)
                begin
                    if (acc_new[31:16] != BPP_24)
                        fail_code = ST_BAD_BPP;
                end
                else if (cur_pos == POS_WIN_COMP)
                begin
                    if (acc_new != 32'd0)
                        fail_code = ST_COMPRESSED;
                    else
                        hdr_done = 1'b1;
                end
            end
            else if (cur_hdr == HDR_OS2)
            begin
                if (cur_pos == POS_OS2_WIDTH || cur_pos == POS_OS2_HEIGHT)
                begin
                    if (os2_bad)
                        fail_code = ST_BAD_SIZE;
                end
                else if (cur_pos == POS_OS2_BPP)
                begin
                    data_start = OS2_DATA_START;
                    if (acc_new[31:16] != BPP_24)
                        fail_code = ST_BAD_BPP;
                    else
                        hdr_done = 1'b1;
                end
            end
            // data offset may not point before the first byte after the last parsed field
            if (hdr_done && offset_reg < data_start)
            begin
                hdr_done  = 1'b0;
                fail_code = ST_BAD_SIZE;
            end
        end
        fail = fail_code != ST_PIXEL;
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (cur_phase)
                PH_SIG:
                begin
                    if (fail)
                        phase_next = PH_HALT;
                    else if (cur_pos != 32'd0)
                        phase_next = PH_HDR;
                    else
                        phase_next = PH_SIG;
                end
                PH_HDR:
                begin
                    if (fail)
                        phase_next = PH_HALT;
                    else if (hdr_done)
                        phase_next = (offset_reg == data_start) ? PH_PIX : PH_SKIP;
                    else
                        phase_next = PH_HDR;
                end
                PH_SKIP:  phase_next = skip_done ? PH_PIX : PH_SKIP;
                PH_PIX:   phase_next = PH_PIX;
                PH_HALT:  phase_next = PH_HALT;
                default:  phase_next = PH_HALT;
            endcase
        end
    end

    // Transaction to the back end
    always_comb
    begin
        tok_valid  = 1'b0;
        tok.kind   = TK_DATA;
        tok.data   = file_bytes.data_byte;
        tok.code   = fail_code;
        tok_width  = width_reg;
        tok_height = height_reg;
        if (accept)
        begin
            unique case (cur_phase)
                PH_SIG, PH_HDR:
                begin
                    if (fail)
                    begin
                        tok_valid = 1'b1;
                        tok.kind  = TK_ERROR;
                    end
                    else if (hdr_done)
                    begin
                        tok_valid = 1'b1;
                        tok.kind  = TK_START;
                    end
                end
                PH_PIX:
                begin
                    tok_valid = 1'b1;
                    tok.kind  = TK_DATA;
                end
                PH_SKIP, PH_HALT:
                begin
                    tok_valid = 1'b0;
                end
                default:
                begin
                    tok_valid = 1'b0;
                end
            endcase
        end
    end

    // Field registers
    always_comb
    begin
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        offset_next = offset_reg;
        hdr_next    = hdr_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (accept)
        begin
            pos_next = cur_pos + 32'd1;
            acc_next = acc_new;
            hdr_next = cur_hdr;
            if (cur_phase == PH_HDR)
            begin
                if (cur_pos == POS_OFFSET)
                    offset_next = acc_new;
                else if (cur_pos == POS_HDR_SIZE)
                    hdr_next = (acc_new == HDR_LEN_WIN) ? HDR_WIN : HDR_OS2;
                else if (cur_hdr == HDR_WIN)
                begin
                    if (cur_pos == POS_WIN_WIDTH)
                        width_next = acc_new[DIM_BITS-1:0];
                    if (cur_pos == POS_WIN_HEIGHT)
                        height_next = acc_new[DIM_BITS-1:0];
                end
                else if (cur_hdr == HDR_OS2)
                begin
                    if (cur_pos == POS_OS2_WIDTH)
                        width_next = os2_val[DIM_BITS-1:0];
                    if (cur_pos == POS_OS2_HEIGHT)
                        height_next = os2_val[DIM_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            pos_reg   <= 32'd0;
            acc_reg   <= 32'd0;
            hdr_reg   <= HDR_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            hdr_reg   <= hdr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        width_reg  <= width_next;
        height_reg <= height_next;
    end

endmodule

// ===== rtl/bmp24_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_queue
// Two-entry register FIFO between the parser and the pixel assembler.
// ----------------------------------------------------------------------------
module bmp24_queue #(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH    = 2;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = count_reg == CNT_BITS'(DEPTH);
    assign valid    = count_reg != '0;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = CNT_BITS'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNT_BITS'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/bmp24_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_back
// Pixel assembler: gathers BGR triples, drops row padding, tracks the
// pixel position and drives the registered result channel.
// ----------------------------------------------------------------------------
module bmp24_back
    import bmp24_pkg::*;
#(
    parameter int DIM_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  tok_t                tok,
    input  logic [DIM_BITS-1:0] tok_width,
    input  logic [DIM_BITS-1:0] tok_height,
    bmp24_pixel_if.source       pixels
);

    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          blue_reg, blue_next;
    logic [11:0]         px_reg, px_next;
    logic [11:0]         py_reg, py_next;
    logic                last_reg, last_next;

    logic                active_reg, active_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [DIM_BITS-1:0] x_reg, x_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    comp_t               comp_reg, comp_next;
    logic [1:0]          pad_reg, pad_next;
    logic [7:0]          held_b_reg, held_b_next;
    logic [7:0]          held_g_reg, held_g_next;

    logic                row_end;
    logic                img_end;

    assign q_pop   = q_valid && (!out_valid_reg || pixels.ready);
    assign row_end = x_reg == DIM_BITS'(width_reg - 1'b1);
    assign img_end = row_end && (row_reg == DIM_BITS'(height_reg - 1'b1));

    always_comb
    begin
        out_valid_next = out_valid_reg && !pixels.ready;
        status_next    = status_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;
        active_next    = active_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        x_next         = x_reg;
        row_next       = row_reg;
        comp_next      = comp_reg;
        pad_next       = pad_reg;
        held_b_next    = held_b_reg;
        held_g_next    = held_g_reg;
        if (q_pop)
        begin
            unique case (tok.kind)
                TK_START:
                begin
                    active_next = 1'b1;
                    width_next  = tok_width;
                    height_next = tok_height;
                    x_next      = '0;
                    row_next    = '0;
                    comp_next   = CMP_BLUE;
                    pad_next    = 2'd0;
                end
                TK_ERROR:
                begin
                    active_next    = 1'b0;
                    out_valid_next = 1'b1;
                    status_next    = tok.code;
                    red_next       = 8'd0;
                    green_next     = 8'd0;
                    blue_next      = 8'd0;
                    px_next        = 12'd0;
                    py_next        = 12'd0;
                    last_next      = 1'b0;
                end
                TK_DATA:
                begin
                    if (active_reg)
                    begin
                        if (pad_reg != 2'd0)
                        begin
                            // padding byte; the row closes on the last one
                            pad_next = pad_reg - 2'd1;
                            if (pad_reg == 2'd1)
                                row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            unique case (comp_reg)
                                CMP_BLUE:
                                begin
                                    held_b_next = tok.data;
                                    comp_next   = CMP_GREEN;
                                end
                                CMP_GREEN:
                                begin
                                    held_g_next = tok.data;
                                    comp_next   = CMP_RED;
                                end
                                CMP_RED:
                                begin
                                    comp_next      = CMP_BLUE;
                                    out_valid_next = 1'b1;
                                    status_next    = ST_PIXEL;
                                    red_next       = tok.data;
                                    green_next     = held_g_reg;
                                    blue_next      = held_b_reg;
                                    px_next        = 12'(x_reg);
                                    py_next        = 12'(row_reg);
                                    last_next      = img_end;
                                    if (img_end)
                                        active_next = 1'b0;
                                    else if (row_end)
                                    begin
                                        // rows pad to four bytes: width mod 4 pad bytes
                                        x_next = '0;
                                        if (width_reg[1:0] == 2'd0)
                                            row_next = row_reg + 1'b1;
                                        else
                                            pad_next = width_reg[1:0];
                                    end
                                    else
                                        x_next = x_reg + 1'b1;
                                end
                                default:
                                begin
                                    comp_next = CMP_BLUE;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            comp_reg      <= CMP_BLUE;
            pad_reg       <= 2'd0;
            x_reg         <= '0;
            row_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            comp_reg      <= comp_next;
            pad_reg       <= pad_next;
            x_reg         <= x_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        held_b_reg <= held_b_next;
        held_g_reg <= held_g_next;
    end

    assign pixels.valid      = out_valid_reg;
    assign pixels.status     = status_reg;
    assign pixels.red        = red_reg;
    assign pixels.green      = green_reg;
    assign pixels.blue       = blue_reg;
    assign pixels.pixel_x    = px_reg;
    assign pixels.pixel_y    = py_reg;
    assign pixels.last_pixel = last_reg;

endmodule

// ===== rtl/bmp24_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Byte-serial decoder for 24-bit bitmap files, RGB pixels out.
// ----------------------------------------------------------------------------
// Feed the file one byte per transaction on file_bytes, with start_of_file set
// on byte zero of each file (after reset the first byte counts as byte zero
// anyway). The block checks the BM signature, takes the 40-byte or the 12-byte
// OS/2 info header, skips to the data offset and returns one pixels
// transaction per BGR triple with red/green/blue, its column, its row in file
// order and last_pixel on the final one. Row padding to four bytes is dropped.
// Any header fault returns a single status transaction (pixel fields zero) and
// the block ignores the rest of that file; everything after the last pixel is
// ignored as well. Throughput is one byte per clock: the parser accepts a byte
// every cycle as long as its two-entry queue has room, and the assembler
// drains the queue one entry per cycle into a single output register while that
// register is free or being read, so a stalled result only blocks input once the
// queue has filled. The third byte of a triple reaches its pixel through the
// queue and then the output register. Image width and height must be
// 1 .. 2^DIM_BITS-1; coordinates are reported in 12 bits.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder
    import bmp24_pkg::*;
#(
    parameter int DIM_BITS = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    bmp24_byte_if.sink    file_bytes,
    bmp24_pixel_if.source pixels
);

    // queue entry: transaction plus image dimensions (used by start entries)
    localparam int Q_WIDTH = $bits(tok_t) + 2 * DIM_BITS;

    logic                f_valid;
    tok_t                f_tok;
    logic [DIM_BITS-1:0] f_width;
    logic [DIM_BITS-1:0] f_height;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic [Q_WIDTH-1:0]  q_data;
    tok_t                b_tok;
    logic [DIM_BITS-1:0] b_width;
    logic [DIM_BITS-1:0] b_height;

    // front end: header parsing and classification
    bmp24_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (file_bytes),
        .q_full     (q_full),
        .tok_valid  (f_valid),
        .tok        (f_tok),
        .tok_width  (f_width),
        .tok_height (f_height)
    );

    bmp24_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data ({f_tok, f_width, f_height}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    assign {b_tok, b_width, b_height} = q_data;

    // back end: pixel assembly and result register
    bmp24_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .tok        (b_tok),
        .tok_width  (b_width),
        .tok_height (b_height),
        .pixels     (pixels)
    );

endmodule
